[src/lpkt_pkg.sv]
// Shared types and constants for the linear-probe key table.
// Depends on nothing; every other file of the block but lpkt_ram uses it.
package lpkt_pkg;

  localparam int HASH_W     = 32;
  localparam int WORD_W     = 64;
  localparam int WORDS      = 4;
  localparam int KEY_W      = WORD_W * WORDS;
  localparam int ENTRY_W    = 2 * KEY_W;
  localparam int LOG2_W     = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int COUNT_W    = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd6;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_MISS = 2'd2,
    STAT_FULL = 2'd3
  } lpkt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } lpkt_state_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } lpkt_cmd_t;

  typedef struct packed {
    lpkt_cmd_t          cmd;
    logic [HASH_W-1:0]  home_hash;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   auth;
  } lpkt_req_t;

  typedef struct packed {
    lpkt_status_t          status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  slot_valid;
    logic [COUNT_W-1:0]    entry_count;
  } lpkt_result_t;

endpackage

[src/lpkt_req_if.sv]
// Request channel of the linear-probe key table: valid, ready and one request.
// Depends on lpkt_pkg for field widths.
interface lpkt_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [lpkt_pkg::HASH_W-1:0]  home_hash;
  logic [lpkt_pkg::WORD_W-1:0]  key_word0;
  logic [lpkt_pkg::WORD_W-1:0]  key_word1;
  logic [lpkt_pkg::WORD_W-1:0]  key_word2;
  logic [lpkt_pkg::WORD_W-1:0]  key_word3;
  logic [lpkt_pkg::WORD_W-1:0]  auth_word0;
  logic [lpkt_pkg::WORD_W-1:0]  auth_word1;
  logic [lpkt_pkg::WORD_W-1:0]  auth_word2;
  logic [lpkt_pkg::WORD_W-1:0]  auth_word3;

  modport source (
    output valid, cmd, home_hash, key_word0, key_word1, key_word2, key_word3,
           auth_word0, auth_word1, auth_word2, auth_word3,
    input  ready
  );

  modport sink (
    input  valid, cmd, home_hash, key_word0, key_word1, key_word2, key_word3,
           auth_word0, auth_word1, auth_word2, auth_word3,
    output ready
  );
endinterface

[src/lpkt_rsp_if.sv]
// Response channel of the linear-probe key table: valid, ready and one result.
// Depends on lpkt_pkg for field widths.
interface lpkt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [lpkt_pkg::SLOT_OUT_W-1:0]  slot_index;
  logic                             slot_valid;
  logic [lpkt_pkg::COUNT_W-1:0]     entry_count;

  modport source (
    output valid, status, slot_index, slot_valid, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, slot_index, slot_valid, entry_count,
    output ready
  );
endinterface

[src/lpkt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lpkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/lpkt_engine.sv]
// Probe sequencer: entry memory, occupancy bits, entry count and the linear probe.
// Depends on lpkt_pkg and lpkt_ram.
module lpkt_engine #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  lpkt_pkg::lpkt_req_t       req,
  input  logic [$clog2(DEPTH)-1:0]  mask,
  output logic                      res_valid,
  input  logic                      res_ready,
  output lpkt_pkg::lpkt_result_t    res
);
  import lpkt_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  lpkt_state_t        state, state_next;
  lpkt_req_t          req_q;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [IDX_W-1:0]   cmp_idx, cmp_idx_next;
  logic [IDX_W-1:0]   left, left_next;
  logic [IDX_W-1:0]   free_slot, free_slot_next;
  logic               free_seen, free_seen_next;
  logic               hit, hit_next;
  logic               auth_ok, auth_ok_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [DEPTH-1:0]   used, used_next;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [ENTRY_W-1:0] rd_data;
  logic [KEY_W-1:0]   rd_key;
  logic [KEY_W-1:0]   rd_auth;
  logic [IDX_W-1:0]   home;
  logic               match;

  lpkt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_slot),
    .wr_data ({req_q.key, req_q.auth}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key  = rd_data[ENTRY_W-1:KEY_W];
  assign rd_auth = rd_data[KEY_W-1:0];
  assign home    = req.home_hash[IDX_W-1:0] & mask;
  assign match   = used[cmp_idx] && (rd_key == req_q.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    rd_idx    <= rd_idx_next;
    cmp_idx   <= cmp_idx_next;
    left      <= left_next;
    free_slot <= free_slot_next;
    free_seen <= free_seen_next;
    hit       <= hit_next;
    auth_ok   <= auth_ok_next;
  end

  always_comb begin
    state_next     = state;
    rd_idx_next    = rd_idx;
    cmp_idx_next   = cmp_idx;
    left_next      = left;
    free_slot_next = free_slot;
    free_seen_next = free_seen;
    hit_next       = hit;
    auth_ok_next   = auth_ok;
    count_next     = count;
    used_next      = used;
    rd_en          = 1'b0;
    rd_addr        = rd_idx;
    wr_en          = 1'b0;
    req_ready      = 1'b0;
    res_valid      = 1'b0;
    res            = '{status: STAT_FULL, slot_index: '0, slot_valid: 1'b0,
                       entry_count: count};

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          rd_en          = 1'b1;
          rd_addr        = home;
          cmp_idx_next   = home;
          rd_idx_next    = (home + IDX_W'(1)) & mask;
          left_next      = mask;
          free_seen_next = 1'b0;
          free_slot_next = '0;
          hit_next       = 1'b0;
          auth_ok_next   = 1'b0;
          state_next     = S_PROBE;
        end
      end

      S_PROBE: begin
        if (match) begin
          hit_next     = 1'b1;
          auth_ok_next = (rd_auth == req_q.auth);
          state_next   = S_FINISH;
        end else begin
          if (!used[cmp_idx] && !free_seen) begin
            free_seen_next = 1'b1;
            free_slot_next = cmp_idx;
          end
          if (left != '0) begin
            rd_en        = 1'b1;
            cmp_idx_next = rd_idx;
            rd_idx_next  = (rd_idx + IDX_W'(1)) & mask;
            left_next    = left - IDX_W'(1);
          end else begin
            state_next = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        res_valid = 1'b1;
        if (hit) begin
          res.status     = (auth_ok && req_q.cmd == CMD_LOOKUP) ? STAT_OK : STAT_DUP;
          res.slot_index = SLOT_OUT_W'(cmp_idx);
          res.slot_valid = 1'b1;
        end else if (req_q.cmd == CMD_LOOKUP) begin
          res.status     = STAT_MISS;
          res.slot_index = free_seen ? SLOT_OUT_W'(free_slot) : '0;
          res.slot_valid = free_seen;
        end else if (free_seen) begin
          res.status      = STAT_OK;
          res.slot_index  = SLOT_OUT_W'(free_slot);
          res.slot_valid  = 1'b1;
          res.entry_count = (count == COUNT_MAX) ? count : count + COUNT_W'(1);
        end
        if (res_ready) begin
          if (!hit && req_q.cmd == CMD_INSERT && free_seen) begin
            wr_en                = 1'b1;
            used_next[free_slot] = 1'b1;
            count_next           = res.entry_count;
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/linear_probe_key_table.sv]
// Linear-probe key table: one result per request. A request probes from its home
// slot until a key matches or the configured slot count has been read (slots
// probed are capped by the table size); the probe reads one slot of the entry
// memory per cycle. A new request is taken while the last result still waits on
// the response channel. Occupancy is cleared by reset at once; there is no
// clearing pass.
// Depends on lpkt_pkg, lpkt_req_if, lpkt_rsp_if and lpkt_engine.
module linear_probe_key_table #(
  parameter int TABLE_SIZE = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lpkt_pkg::LOG2_W-1:0]  cfg_wr_data,
  lpkt_req_if.sink                     req,
  lpkt_rsp_if.source                   rsp
);
  import lpkt_pkg::*;

  localparam int FLOOR_LOG2 = $clog2(TABLE_SIZE + 1) - 1;
  localparam int MAX_LOG2   = (FLOOR_LOG2 > 7) ? 7 : FLOOR_LOG2;
  localparam int DEPTH      = 1 << MAX_LOG2;
  localparam int IDX_W      = MAX_LOG2;

  logic [LOG2_W-1:0] size_cfg;
  logic [LOG2_W-1:0] size_log2;
  logic [IDX_W-1:0]  mask;
  lpkt_req_t         req_bus;
  lpkt_result_t      res;
  logic              res_valid;
  logic              res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= LOG2_RESET;
    end else if (cfg_wr_en) begin
      size_cfg <= cfg_wr_data;
    end
  end

  assign size_log2 = (int'(size_cfg) > MAX_LOG2) ? LOG2_W'(MAX_LOG2)
                                                 : size_cfg;
  assign mask      = IDX_W'((1 << size_log2) - 1);

  assign req_bus.cmd       = lpkt_cmd_t'(req.cmd);
  assign req_bus.home_hash = req.home_hash;
  assign req_bus.key       = {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
  assign req_bus.auth      = {req.auth_word3, req.auth_word2, req.auth_word1,
                              req.auth_word0};

  lpkt_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req       (req_bus),
    .mask      (mask),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // hold the result until transfer
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp.status      <= res.status;
      rsp.slot_index  <= res.slot_index;
      rsp.slot_valid  <= res.slot_valid;
      rsp.entry_count <= res.entry_count;
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench for linear_probe_key_table: directed rows, then random requests in phases
// of table size, each result checked against its typed row or a cycle-free probe model.
// Depends on lpkt_pkg, lpkt_req_if, lpkt_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import lpkt_pkg::*;

  localparam int SLOTS = 64;
  localparam int SLOT_LOG2 = 6;
  localparam int NO_CFG = -1;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int PHASES = 10;
  localparam logic [KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_A = {WORDS{64'h0123_4567_89ab_cdef}};
  localparam logic [KEY_W-1:0] KEY_B = {WORDS{64'hfedc_ba98_7654_3210}};
  localparam logic [KEY_W-1:0] KEY_C = {WORDS{64'h5a5a_a5a5_0f0f_f0f0}};
  localparam logic [KEY_W-1:0] KEY_D = {WORDS{64'h8000_0000_0000_0001}};
  localparam logic [KEY_W-1:0] AUTH_A = {WORDS{64'h1111_2222_3333_4444}};
  localparam logic [KEY_W-1:0] AUTH_B = {WORDS{64'h9999_aaaa_bbbb_cccc}};
  localparam logic [KEY_W-1:0] AUTH_C = {WORDS{64'h0f1e_2d3c_4b5a_6978}};
  localparam logic [KEY_W-1:0] AUTH_D = {WORDS{64'hdead_0000_beef_ffff}};

  typedef struct {
    int           cfg;
    lpkt_req_t    req;
    bit           typed;
    lpkt_result_t res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [LOG2_W-1:0] cfg_wr_data;

  lpkt_req_if req_if ();
  lpkt_rsp_if rsp_if ();

  linear_probe_key_table #(
    .TABLE_SIZE(SLOTS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  // model of the table
  logic              slot_taken [SLOTS];
  logic [KEY_W-1:0]  key_mem [SLOTS];
  logic [KEY_W-1:0]  auth_mem [SLOTS];
  logic [COUNT_W-1:0] occupied;
  logic [LOG2_W-1:0] table_log2;

  lpkt_result_t expected_results [$];
  lpkt_req_t    key_pool [$];
  stim_row_t    stim_rows [$];
  int           mismatches = 0;
  int           send_gap_pct = 25;
  int           recv_gap_pct = 56;
  int           phase_log2 [PHASES] = '{3, 7, 0, 5, 1, 6, 2, 4, 7, 6};

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic lpkt_result_t probe_table(input lpkt_req_t r);
    int unsigned span, mask, idx, free_at, hit_at, n;
    bit free_seen, hit, auth_ok;
    lpkt_result_t res;
    span = 1 << ((table_log2 > SLOT_LOG2) ? SLOT_LOG2 : int'(table_log2));
    mask = span - 1;
    idx = r.home_hash & mask;
    free_seen = 1'b0;
    hit = 1'b0;
    auth_ok = 1'b0;
    free_at = 0;
    hit_at = 0;
    for (n = 0; n < span; n++) begin
      if (!slot_taken[idx]) begin
        if (!free_seen) begin
          free_seen = 1'b1;
          free_at = idx;
        end
      end else if (key_mem[idx] == r.key) begin
        hit = 1'b1;
        hit_at = idx;
        auth_ok = (auth_mem[idx] == r.auth);
        break;
      end
      idx = (idx + 1) & mask;
    end
    res.slot_index = '0;
    res.slot_valid = 1'b0;
    if (hit) begin
      if (auth_ok && r.cmd == CMD_LOOKUP) res.status = STAT_OK;
      else res.status = STAT_DUP;
      res.slot_index = SLOT_OUT_W'(hit_at);
      res.slot_valid = 1'b1;
    end else if (r.cmd == CMD_LOOKUP) begin
      res.status = STAT_MISS;
      if (free_seen) begin
        res.slot_index = SLOT_OUT_W'(free_at);
        res.slot_valid = 1'b1;
      end
    end else if (free_seen) begin
      slot_taken[free_at] = 1'b1;
      key_mem[free_at] = r.key;
      auth_mem[free_at] = r.auth;
      if (occupied != COUNT_MAX) occupied = occupied + 1'b1;
      res.status = STAT_OK;
      res.slot_index = SLOT_OUT_W'(free_at);
      res.slot_valid = 1'b1;
    end else begin
      res.status = STAT_FULL;
    end
    res.entry_count = occupied;
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] rand_256();
    logic [KEY_W-1:0] v;
    for (int i = 0; i < KEY_W / 32; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic stim_row_t mk_row(input int cfg, input lpkt_cmd_t cmd,
                                       input logic [HASH_W-1:0] hash,
                                       input logic [KEY_W-1:0] key,
                                       input logic [KEY_W-1:0] auth, input bit typed,
                                       input lpkt_status_t st, input int slot,
                                       input bit sv, input int cnt);
    stim_row_t row;
    row.cfg = cfg;
    row.req.cmd = cmd;
    row.req.home_hash = hash;
    row.req.key = key;
    row.req.auth = auth;
    row.typed = typed;
    row.res.status = st;
    row.res.slot_index = SLOT_OUT_W'(slot);
    row.res.slot_valid = sv;
    row.res.entry_count = COUNT_W'(cnt);
    return row;
  endfunction

  task automatic drive_req(input lpkt_req_t r, input bit typed,
                           input lpkt_result_t typed_res);
    lpkt_result_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= r.cmd;
    req_if.home_hash  <= r.home_hash;
    req_if.key_word0  <= r.key[63:0];
    req_if.key_word1  <= r.key[127:64];
    req_if.key_word2  <= r.key[191:128];
    req_if.key_word3  <= r.key[255:192];
    req_if.auth_word0 <= r.auth[63:0];
    req_if.auth_word1 <= r.auth[127:64];
    req_if.auth_word2 <= r.auth[191:128];
    req_if.auth_word3 <= r.auth[255:192];
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = probe_table(r);
    expected_results.push_back(typed ? typed_res : predicted);
    if (r.cmd == CMD_INSERT) key_pool.push_back(r);
  endtask

  task automatic set_table_log2(input logic [LOG2_W-1:0] v);
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    table_log2 = v;
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // check each result transfer, then pick the next ready
  always @(posedge clk) begin
    lpkt_result_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual status %0d",
                   $time, rsp_if.status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 8'(want.status), 8'(rsp_if.status));
          check_field("slot_index", 8'(want.slot_index), 8'(rsp_if.slot_index));
          check_field("slot_valid", 8'(want.slot_valid), 8'(rsp_if.slot_valid));
          check_field("entry_count", 8'(want.entry_count), 8'(rsp_if.entry_count));
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    lpkt_req_t r;
    lpkt_req_t seen;
    int pick;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_if.valid = 1'b0;
    req_if.cmd = 1'b0;
    req_if.home_hash = '0;
    req_if.key_word0 = '0;
    req_if.key_word1 = '0;
    req_if.key_word2 = '0;
    req_if.key_word3 = '0;
    req_if.auth_word0 = '0;
    req_if.auth_word1 = '0;
    req_if.auth_word2 = '0;
    req_if.auth_word3 = '0;
    for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
    occupied = '0;
    table_log2 = LOG2_RESET;

    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'h0000_0000, KEY_ZERO, KEY_ZERO,
                               1, STAT_MISS, 0, 1, 0));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'hffff_ffff, KEY_ONES, KEY_ONES,
                               1, STAT_MISS, 63, 1, 0));
    stim_rows.push_back(mk_row(NO_CFG, CMD_INSERT, 32'h0000_0000, KEY_ZERO, KEY_ZERO,
                               1, STAT_OK, 0, 1, 1));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'h0000_0000, KEY_ZERO, KEY_ZERO,
                               1, STAT_OK, 0, 1, 1));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'h0000_0000, KEY_ZERO, AUTH_A,
                               1, STAT_DUP, 0, 1, 1));
    stim_rows.push_back(mk_row(NO_CFG, CMD_INSERT, 32'h0000_0000, KEY_ZERO, KEY_ZERO,
                               1, STAT_DUP, 0, 1, 1));
    stim_rows.push_back(mk_row(NO_CFG, CMD_INSERT, 32'h0000_0000, KEY_ZERO, AUTH_A,
                               1, STAT_DUP, 0, 1, 1));
    stim_rows.push_back(mk_row(NO_CFG, CMD_INSERT, 32'hffff_ffff, KEY_ONES, KEY_ONES,
                               1, STAT_OK, 63, 1, 2));
    stim_rows.push_back(mk_row(NO_CFG, CMD_INSERT, 32'h0000_003f, KEY_A, AUTH_A,
                               0, STAT_OK, 0, 0, 0));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'h0000_003f, KEY_A, AUTH_A,
                               1, STAT_OK, 1, 1, 3));
    stim_rows.push_back(mk_row(0, CMD_LOOKUP, 32'hffff_ffff, KEY_A, AUTH_A,
                               1, STAT_MISS, 0, 0, 3));
    stim_rows.push_back(mk_row(NO_CFG, CMD_INSERT, 32'h1234_5678, KEY_B, AUTH_B,
                               1, STAT_FULL, 0, 0, 3));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'hffff_fffe, KEY_ZERO, KEY_ZERO,
                               1, STAT_OK, 0, 1, 3));
    stim_rows.push_back(mk_row(7, CMD_LOOKUP, 32'h0000_0000, KEY_ONES, KEY_ONES,
                               0, STAT_OK, 0, 0, 0));
    stim_rows.push_back(mk_row(1, CMD_INSERT, 32'h0000_0001, KEY_B, AUTH_B,
                               1, STAT_FULL, 0, 0, 3));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'h0000_0001, KEY_ONES, KEY_ONES,
                               1, STAT_MISS, 0, 0, 3));
    stim_rows.push_back(mk_row(2, CMD_INSERT, 32'h8000_0001, KEY_B, AUTH_B,
                               1, STAT_OK, 2, 1, 4));
    stim_rows.push_back(mk_row(NO_CFG, CMD_INSERT, 32'h0000_0002, KEY_C, AUTH_C,
                               1, STAT_OK, 3, 1, 5));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'h0000_0003, KEY_D, AUTH_D,
                               1, STAT_MISS, 0, 0, 5));
    stim_rows.push_back(mk_row(6, CMD_LOOKUP, 32'h0000_0002, KEY_C, AUTH_C,
                               0, STAT_OK, 0, 0, 0));
    stim_rows.push_back(mk_row(NO_CFG, CMD_INSERT, 32'h0000_0000, KEY_D, AUTH_D,
                               1, STAT_OK, 4, 1, 6));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'h0000_0004, KEY_D, AUTH_C,
                               1, STAT_DUP, 4, 1, 6));
    stim_rows.push_back(mk_row(NO_CFG, CMD_LOOKUP, 32'h7fff_ffc0, KEY_ONES,
                               {1'b0, {(KEY_W-1){1'b1}}}, 0, STAT_OK, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].cfg != NO_CFG) set_table_log2(LOG2_W'(stim_rows[i].cfg));
      drive_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].res);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        send_gap_pct = 56;
        recv_gap_pct = 25;
      end else if (p == 7) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      set_table_log2(LOG2_W'(phase_log2[p]));
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        r.cmd = CMD_LOOKUP;
        r.home_hash = $urandom;
        r.key = rand_256();
        r.auth = rand_256();
        if (pick < 2) begin
          r.cmd = CMD_INSERT;
        end else if (pick < 8) begin
          r.cmd = lpkt_cmd_t'($urandom_range(0, 1));
        end else if (pick >= 26) begin
          // reuse a key already offered for insertion
          seen = key_pool[$urandom_range(0, key_pool.size() - 1)];
          r.key = seen.key;
          if ($urandom_range(0, 3) != 0) r.home_hash = seen.home_hash;
          if (pick < 62) begin
            r.auth = seen.auth;
          end else if (pick < 76) begin
            r.auth = seen.auth ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
          end else begin
            r.cmd = CMD_INSERT;
            if ($urandom_range(0, 1) != 0) r.auth = seen.auth;
          end
        end
        drive_req(r, 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
src/lpkt_pkg.sv
src/lpkt_req_if.sv
src/lpkt_rsp_if.sv
src/lpkt_ram.sv
src/lpkt_engine.sv
src/linear_probe_key_table.sv
sim/tb_top.sv
